// ===== src/bstplf_pkg.sv =====
// ----------------------------------------------------------------------------
// bstplf_pkg
// Shared types and defaults for the preorder leaf finder.
// ----------------------------------------------------------------------------
package bstplf_pkg;

	localparam int DEFAULT_STACK_DEPTH = 1024;
	localparam int DEFAULT_KEY_BITS    = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PUSH,
		ST_EMIT_PREV,
		ST_EMIT_LAST
	} state_t;

endpackage

// ===== src/bstplf_key_if.sv =====
// ----------------------------------------------------------------------------
// bstplf_key_if
// Input channel: one preorder key per item, with a last-key marker.
// ----------------------------------------------------------------------------
interface bstplf_key_if #(
	parameter int KEY_BITS = bstplf_pkg::DEFAULT_KEY_BITS
);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] key;
	logic                final_key;

	modport source (output valid, output key, output final_key, input ready);
	modport sink   (input valid, input key, input final_key, output ready);
endinterface

// ===== src/bstplf_leaf_if.sv =====
// ----------------------------------------------------------------------------
// bstplf_leaf_if
// Output channel: one detected leaf per transfer.
// ----------------------------------------------------------------------------
interface bstplf_leaf_if #(
	parameter int KEY_BITS = bstplf_pkg::DEFAULT_KEY_BITS
);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] leaf_key;
	logic                last_leaf;
	logic                stack_overflow;

	modport source (output valid, output leaf_key, output last_leaf,
		output stack_overflow, input ready);
	modport sink   (input valid, input leaf_key, input last_leaf,
		input stack_overflow, output ready);
endinterface

// ===== src/bst_preorder_leaf_finder.sv =====
// Flow: an accepted key reads the stack top when the stack is not empty, the
//   compare state then pops every stacked key smaller than it, and the push
//   state stores it; 0 to 2 results follow, each waiting for a free output register.
// A new key is taken only once the last item is done, since ready is high only in idle;
//   each key is popped at most once. The registered stack read sets the pop rate.
// Reset (arst_n low): stack empty, previous key and overflow flag cleared.
// ----------------------------------------------------------------------------
// bst_preorder_leaf_finder
// Finds the leaves of a BST from its preorder key stream using a stack.
// ----------------------------------------------------------------------------
module bst_preorder_leaf_finder #(
	parameter int STACK_DEPTH = bstplf_pkg::DEFAULT_STACK_DEPTH,
	parameter int KEY_BITS    = bstplf_pkg::DEFAULT_KEY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bstplf_key_if.sink           keys,
	bstplf_leaf_if.source        leaves
);

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

	bstplf_pkg::state_t state_q, state_nxt;

	logic [KEY_BITS-1:0] mem [STACK_DEPTH];
	logic [KEY_BITS-1:0] rd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] prev_item_q;
	logic [KEY_BITS-1:0] prev_key_q;
	logic                fin_q;
	logic [1:0]          pops_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q;

	logic [KEY_BITS-1:0] out_key_q;
	logic                out_last_q;
	logic                out_ovf_q;
	logic                out_valid_q;

	logic [CNT_W-1:0]    cnt_m1;
	logic [CNT_W-1:0]    cnt_m2;
	logic                accept;
	logic                out_free;
	logic                key_gt;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic                do_pop;
	logic                do_push;
	logic                load_prev;
	logic                load_last;

	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign cnt_m2   = cnt_q - CNT_W'(2);
	assign accept   = keys.valid && keys.ready;
	assign out_free = !out_valid_q || leaves.ready;
	assign key_gt   = key_q > rd_q;

	assign keys.ready            = (state_q == bstplf_pkg::ST_IDLE);
	assign leaves.valid          = out_valid_q;
	assign leaves.leaf_key       = out_key_q;
	assign leaves.last_leaf      = out_last_q;
	assign leaves.stack_overflow = out_ovf_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bstplf_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = (cnt_q != '0) ? bstplf_pkg::ST_CMP : bstplf_pkg::ST_PUSH;
				end
			end
			bstplf_pkg::ST_CMP: begin
				if (!key_gt || cnt_q == CNT_W'(1)) begin
					state_nxt = bstplf_pkg::ST_PUSH;
				end
			end
			bstplf_pkg::ST_PUSH: begin
				priority if (pops_q == 2'd2) begin
					state_nxt = bstplf_pkg::ST_EMIT_PREV;
				end else if (fin_q) begin
					state_nxt = bstplf_pkg::ST_EMIT_LAST;
				end else begin
					state_nxt = bstplf_pkg::ST_IDLE;
				end
			end
			bstplf_pkg::ST_EMIT_PREV: begin
				if (out_free) begin
					state_nxt = fin_q ? bstplf_pkg::ST_EMIT_LAST : bstplf_pkg::ST_IDLE;
				end
			end
			bstplf_pkg::ST_EMIT_LAST: begin
				if (out_free) begin
					state_nxt = bstplf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = bstplf_pkg::ST_IDLE;
		endcase
	end

	// controls
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = cnt_m1[ADDR_W-1:0];
		do_pop    = 1'b0;
		do_push   = 1'b0;
		load_prev = 1'b0;
		load_last = 1'b0;
		unique case (state_q)
			bstplf_pkg::ST_IDLE: begin
				rd_en = accept && (cnt_q != '0);
			end
			bstplf_pkg::ST_CMP: begin
				do_pop  = key_gt;
				rd_en   = key_gt && (cnt_q > CNT_W'(1));
				rd_addr = cnt_m2[ADDR_W-1:0];
			end
			bstplf_pkg::ST_PUSH: begin
				do_push = 1'b1;
			end
			bstplf_pkg::ST_EMIT_PREV: begin
				load_prev = out_free;
			end
			bstplf_pkg::ST_EMIT_LAST: begin
				load_last = out_free;
			end
			default: ;
		endcase
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (do_push && cnt_q < CNT_W'(STACK_DEPTH)) begin
			mem[cnt_q[ADDR_W-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q       <= keys.key;
			fin_q       <= keys.final_key;
			prev_item_q <= prev_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bstplf_pkg::ST_IDLE;
			cnt_q      <= '0;
			prev_key_q <= '0;
			ovf_q      <= 1'b0;
			pops_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				pops_q <= '0;
			end else if (do_pop && pops_q != 2'd2) begin
				pops_q <= pops_q + 2'd1;
			end
			if (do_pop) begin
				cnt_q <= cnt_m1;
			end else if (do_push) begin
				if (fin_q) begin
					cnt_q <= '0;
				end else if (cnt_q < CNT_W'(STACK_DEPTH)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (do_push) begin
				prev_key_q <= fin_q ? '0 : key_q;
				if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_prev) begin
			out_key_q  <= prev_item_q;
			out_last_q <= 1'b0;
			out_ovf_q  <= ovf_q;
		end else if (load_last) begin
			out_key_q  <= key_q;
			out_last_q <= 1'b1;
			out_ovf_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_prev || load_last) begin
			out_valid_q <= 1'b1;
		end else if (leaves.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag cleared");

	a_cmp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bstplf_pkg::ST_CMP |-> cnt_q != '0)
		else $error("compare on empty stack");

	a_last_needs_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bstplf_pkg::ST_EMIT_LAST |-> fin_q)
		else $error("last leaf for non-final item");

	a_emit_prev_pops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bstplf_pkg::ST_EMIT_PREV |-> pops_q == 2'd2)
		else $error("leaf emitted with fewer than two pops");
`endif

endmodule
